// ===== hw/rtl/pdwe_pkg.sv =====
// Shared types and constants for the pulse distance/width encoder.
// Holds payload structs, the queue entry, queue status and register map.
// No dependencies.
package pdwe_pkg;

  localparam int PDWE_MAX_BITS    = 32;
  localparam int PDWE_QUEUE_DEPTH = 2;
  localparam int PDWE_ADDR_W      = 5;
  localparam int PDWE_DATA_W      = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_ONE_MARK   = 3'd0;
  localparam logic [2:0] REG_ONE_SPACE  = 3'd1;
  localparam logic [2:0] REG_ZERO_MARK  = 3'd2;
  localparam logic [2:0] REG_ZERO_SPACE = 3'd3;
  localparam logic [2:0] REG_MSB_FIRST  = 3'd4;
  localparam logic [2:0] REG_SEND_STOP  = 3'd5;

  localparam logic [15:0] RST_ONE_MARK   = 16'd560;
  localparam logic [15:0] RST_ONE_SPACE  = 16'd1690;
  localparam logic [15:0] RST_ZERO_MARK  = 16'd560;
  localparam logic [15:0] RST_ZERO_SPACE = 16'd560;
  localparam logic        RST_MSB_FIRST  = 1'b0;
  localparam logic        RST_SEND_STOP  = 1'b1;

  typedef struct packed {
    logic [31:0] data_word;
    logic [5:0]  bit_count;
  } pdwe_in_t;

  typedef struct packed {
    logic [15:0] mark_time;
    logic [15:0] space_time;
    logic        is_stop;
    logic        last_symbol;
  } pdwe_out_t;

  // one classified word waiting for the serializer
  typedef struct packed {
    logic [31:0] data;
    logic [5:0]  count;
    logic        msb_first;
    logic        stop;
  } pdwe_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pdwe_qstat_t;

endpackage

// ===== hw/rtl/pdwe_front.sv =====
// Front end: accepts input words, saturates the bit count, drops empty runs.
// Depends on pdwe_pkg.
module pdwe_front import pdwe_pkg::*; #(
  parameter int MAX_BITS = PDWE_MAX_BITS
) (
  input  logic        in_valid,
  output logic        in_ready,
  input  pdwe_in_t    in_data,
  input  logic        msb_first,
  input  logic        send_stop,
  input  pdwe_qstat_t q_stat,
  output logic        push,
  output pdwe_job_t   job
);

  localparam logic [5:0] MAX_CNT = 6'(MAX_BITS);

  logic [5:0] count_sat;
  logic       has_work;

  always_comb begin
    count_sat = (in_data.bit_count > MAX_CNT) ? MAX_CNT : in_data.bit_count;
    has_work  = (count_sat != 6'd0) || send_stop;
  end

  // a word with no data bits and no stop symbol is taken and dropped
  assign in_ready      = !q_stat.full;
  assign push          = in_valid && !q_stat.full && has_work;
  assign job.data      = in_data.data_word;
  assign job.count     = count_sat;
  assign job.msb_first = msb_first;
  assign job.stop      = send_stop;

endmodule

// ===== hw/rtl/pdwe_queue.sv =====
// Short queue of classified words between front end and serializer.
// Depends on pdwe_pkg.
module pdwe_queue import pdwe_pkg::*; #(
  parameter int DEPTH = PDWE_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  pdwe_job_t   wr_job,
  input  logic        pop,
  output pdwe_job_t   rd_job,
  output pdwe_qstat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pdwe_job_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  assign rd_job     = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

// ===== hw/rtl/pdwe_back.sv =====
// Back end: queued word to mark/space symbols, one a cycle unless stalled.
// Depends on pdwe_pkg.
module pdwe_back import pdwe_pkg::*; #(
  parameter int MAX_BITS = PDWE_MAX_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  pdwe_qstat_t q_stat,
  input  pdwe_job_t   job,
  output logic        pop,
  input  logic [15:0] one_mark,
  input  logic [15:0] one_space,
  input  logic [15:0] zero_mark,
  input  logic [15:0] zero_space,
  output logic        out_valid,
  input  logic        out_ready,
  output pdwe_out_t   out_data
);

  localparam int IDX_W = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam int CNT_W = $clog2(MAX_BITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DATA = 3'b010,
    ST_STOP = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [MAX_BITS-1:0] data_r, data_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0]    left_r, left_nxt;
  logic                msb_r, msb_nxt;
  logic                stop_r, stop_nxt;
  logic                out_valid_r, out_valid_nxt;
  pdwe_out_t           out_r, out_nxt;
  logic                advance;
  logic                cur_bit;

  assign advance = !out_valid_r || out_ready;
  assign cur_bit = data_r[pos_r];
  assign pop     = (state_r == ST_IDLE) && !q_stat.empty;

  always_comb begin
    state_nxt     = state_r;
    data_nxt      = data_r;
    pos_nxt       = pos_r;
    left_nxt      = left_r;
    msb_nxt       = msb_r;
    stop_nxt      = stop_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          data_nxt  = job.data[MAX_BITS-1:0];
          left_nxt  = job.count[CNT_W-1:0];
          msb_nxt   = job.msb_first;
          stop_nxt  = job.stop;
          pos_nxt   = job.msb_first ? IDX_W'(job.count - 6'd1) : '0;
          state_nxt = (job.count != 6'd0) ? ST_DATA : ST_STOP;
        end
      end
      ST_DATA: begin
        if (advance) begin
          out_valid_nxt       = 1'b1;
          out_nxt.mark_time   = cur_bit ? one_mark : zero_mark;
          out_nxt.space_time  = cur_bit ? one_space : zero_space;
          out_nxt.is_stop     = 1'b0;
          out_nxt.last_symbol = (left_r == CNT_W'(1)) && !stop_r;
          left_nxt            = left_r - CNT_W'(1);
          pos_nxt             = msb_r ? pos_r - IDX_W'(1) : pos_r + IDX_W'(1);
          if (left_r == CNT_W'(1)) begin
            state_nxt = stop_r ? ST_STOP : ST_IDLE;
          end
        end
      end
      ST_STOP: begin
        if (advance) begin
          out_valid_nxt       = 1'b1;
          out_nxt.mark_time   = zero_mark;
          out_nxt.space_time  = '0;
          out_nxt.is_stop     = 1'b1;
          out_nxt.last_symbol = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    pos_r  <= pos_nxt;
    left_r <= left_nxt;
    msb_r  <= msb_nxt;
    stop_r <= stop_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a run ends only right after its last symbol has been loaded
  a_run_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) && (state_nxt == ST_IDLE) |=> out_valid_r && out_r.last_symbol)
    else $error("run ended without a last symbol");

  a_stop_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.is_stop |-> out_r.last_symbol && (out_r.space_time == 16'd0))
    else $error("stop symbol malformed");

  a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DATA) |-> (left_r != '0))
    else $error("data state with no bits left");

endmodule

// ===== hw/rtl/pulse_distance_width_encoder_unit.sv =====
// Top level of the pulse distance/width encoder: config registers, front end,
// job queue and serializer. Depends on pdwe_pkg, pdwe_front, pdwe_queue, pdwe_back.
//
//  channel  | ports                                    | moves
//  ---------+------------------------------------------+-------------------------
//  input    | in_valid, in_ready, in_data              | one word + bit count
//  result   | out_valid, out_ready, out_data           | one mark/space symbol
//  config   | cfg_psel/penable/pwrite/paddr/pwdata,    | register write or read
//           | cfg_prdata, cfg_pready                   |
//
// A word of N data bits (saturated to MAX_BITS) gives N symbols plus one stop
// symbol when enabled; after a load step the serializer emits one symbol per
// cycle while the result side does not stall. The front end keeps taking
// words while the queue has room, so the input stalls only when the queue
// is full. A stalled result word holds in the output register. Reset (rst_n
// low, synchronous) empties the queue and serializer and returns the
// registers to their default timing.
module pulse_distance_width_encoder_unit import pdwe_pkg::*; #(
  parameter int MAX_BITS    = PDWE_MAX_BITS,
  parameter int QUEUE_DEPTH = PDWE_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  pdwe_in_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output pdwe_out_t              out_data,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [PDWE_ADDR_W-1:0] cfg_paddr,
  input  logic [PDWE_DATA_W-1:0] cfg_pwdata,
  output logic [PDWE_DATA_W-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  logic [15:0] one_mark_r, one_mark_nxt;
  logic [15:0] one_space_r, one_space_nxt;
  logic [15:0] zero_mark_r, zero_mark_nxt;
  logic [15:0] zero_space_r, zero_space_nxt;
  logic        msb_first_r, msb_first_nxt;
  logic        send_stop_r, send_stop_nxt;
  logic        wr_en;
  logic [2:0]  reg_idx;

  pdwe_qstat_t q_stat;
  pdwe_job_t   wr_job;
  pdwe_job_t   rd_job;
  logic        push;
  logic        pop;

  // register select: word address, low byte bits ignored
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    one_mark_nxt   = one_mark_r;
    one_space_nxt  = one_space_r;
    zero_mark_nxt  = zero_mark_r;
    zero_space_nxt = zero_space_r;
    msb_first_nxt  = msb_first_r;
    send_stop_nxt  = send_stop_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ONE_MARK:   one_mark_nxt   = cfg_pwdata[15:0];
        REG_ONE_SPACE:  one_space_nxt  = cfg_pwdata[15:0];
        REG_ZERO_MARK:  zero_mark_nxt  = cfg_pwdata[15:0];
        REG_ZERO_SPACE: zero_space_nxt = cfg_pwdata[15:0];
        REG_MSB_FIRST:  msb_first_nxt  = cfg_pwdata[0];
        REG_SEND_STOP:  send_stop_nxt  = cfg_pwdata[0];
        default: ;  // drop writes to unmapped addresses
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_mark_r   <= RST_ONE_MARK;
      one_space_r  <= RST_ONE_SPACE;
      zero_mark_r  <= RST_ZERO_MARK;
      zero_space_r <= RST_ZERO_SPACE;
      msb_first_r  <= RST_MSB_FIRST;
      send_stop_r  <= RST_SEND_STOP;
    end else begin
      one_mark_r   <= one_mark_nxt;
      one_space_r  <= one_space_nxt;
      zero_mark_r  <= zero_mark_nxt;
      zero_space_r <= zero_space_nxt;
      msb_first_r  <= msb_first_nxt;
      send_stop_r  <= send_stop_nxt;
    end
  end

  // read back: unmapped addresses read as zero
  always_comb begin
    cfg_prdata = '0;
    unique case (reg_idx)
      REG_ONE_MARK:   cfg_prdata = PDWE_DATA_W'(one_mark_r);
      REG_ONE_SPACE:  cfg_prdata = PDWE_DATA_W'(one_space_r);
      REG_ZERO_MARK:  cfg_prdata = PDWE_DATA_W'(zero_mark_r);
      REG_ZERO_SPACE: cfg_prdata = PDWE_DATA_W'(zero_space_r);
      REG_MSB_FIRST:  cfg_prdata = PDWE_DATA_W'(msb_first_r);
      REG_SEND_STOP:  cfg_prdata = PDWE_DATA_W'(send_stop_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // classify incoming words and drop those that produce nothing
  pdwe_front #(
    .MAX_BITS(MAX_BITS)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .msb_first(msb_first_r),
    .send_stop(send_stop_r),
    .q_stat   (q_stat),
    .push     (push),
    .job      (wr_job)
  );

  // decouple the accept side from the serializer
  pdwe_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wr_job(wr_job),
    .pop   (pop),
    .rd_job(rd_job),
    .stat  (q_stat)
  );

  // emit one symbol per cycle into the output register unless stalled
  pdwe_back #(
    .MAX_BITS(MAX_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .job       (rd_job),
    .pop       (pop),
    .one_mark  (one_mark_r),
    .one_space (one_space_r),
    .zero_mark (zero_mark_r),
    .zero_space(zero_space_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== bench/pulse_distance_width_encoder_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for pulse_distance_width_encoder_unit: APB register setup, words
// with random idling and a long output hold-off, symbol stream checked in order.
// Depends on pdwe_pkg and the encoder RTL only.
module pulse_distance_width_encoder_unit_tb import pdwe_pkg::*;;

  // register slots past the map; writes there must leave the timing untouched
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  // a word holds the serializer for its load and symbols; the queue holds two more
  localparam int DRAIN_CYCLES    = 64;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WORDS_PER_PHASE = 60;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  pdwe_in_t               in_data;
  logic                   out_valid;
  logic                   out_ready;
  pdwe_out_t              out_data;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [PDWE_ADDR_W-1:0] cfg_paddr;
  logic [PDWE_DATA_W-1:0] cfg_pwdata;
  logic [PDWE_DATA_W-1:0] cfg_prdata;
  logic                   cfg_pready;

  // register image as last written over APB
  logic [15:0] one_mark_q;
  logic [15:0] one_space_q;
  logic [15:0] zero_mark_q;
  logic [15:0] zero_space_q;
  logic        msb_first_q;
  logic        stop_en_q;

  pdwe_out_t pending_symbols[$];  // symbols owed by the block, oldest first
  int        mismatch_count;
  bit        in_idle_en;
  bit        out_idle_en;
  int        hold_off_req;        // nonzero asks the receiver for one long stall, sized by it

  pulse_distance_width_encoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expand one accepted word into its symbols: clamp the count to the data width,
  // walk the bits in the selected order, append the stop mark when enabled and
  // flag the final symbol. A zero count with the stop mark off owes nothing.
  function automatic void encode_word(input pdwe_in_t w);
    int        n_bits;
    int        total;
    int        pos;
    int        k;
    logic      bit_val;
    pdwe_out_t sym;
    n_bits = (w.bit_count > PDWE_MAX_BITS) ? PDWE_MAX_BITS : int'(w.bit_count);
    total  = n_bits + (stop_en_q ? 1 : 0);
    for (k = 0; k < n_bits; k++) begin
      pos             = msb_first_q ? (n_bits - 1 - k) : k;
      bit_val         = w.data_word[pos];
      sym.mark_time   = bit_val ? one_mark_q : zero_mark_q;
      sym.space_time  = bit_val ? one_space_q : zero_space_q;
      sym.is_stop     = 1'b0;
      sym.last_symbol = (k == total - 1);
      pending_symbols.push_back(sym);
    end
    if (stop_en_q) begin
      sym.mark_time   = zero_mark_q;
      sym.space_time  = '0;
      sym.is_stop     = 1'b1;
      sym.last_symbol = 1'b1;
      pending_symbols.push_back(sym);
    end
  endfunction

  // One APB write: setup, then access until pready. psel stays up afterwards so
  // writes can go back to back; release_cfg_bus drops it after a batch.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_ONE_MARK:   one_mark_q   = val[15:0];
      REG_ONE_SPACE:  one_space_q  = val[15:0];
      REG_ZERO_MARK:  zero_mark_q  = val[15:0];
      REG_ZERO_SPACE: zero_space_q = val[15:0];
      REG_MSB_FIRST:  msb_first_q  = val[0];
      REG_SEND_STOP:  stop_en_q    = val[0];
      default: ;
    endcase
  endtask

  task automatic release_cfg_bus();
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Write the whole register map; only call while the block is idle.
  task automatic load_timing(input logic [31:0] one_mark, input logic [31:0] one_space,
                             input logic [31:0] zero_mark, input logic [31:0] zero_space,
                             input logic [31:0] msb_first, input logic [31:0] send_stop);
    write_reg(REG_ONE_MARK, one_mark);
    write_reg(REG_ONE_SPACE, one_space);
    write_reg(REG_ZERO_MARK, zero_mark);
    write_reg(REG_ZERO_SPACE, zero_space);
    write_reg(REG_MSB_FIRST, msb_first);
    write_reg(REG_SEND_STOP, send_stop);
    release_cfg_bus();
  endtask

  // Offer one word and hold it until taken. valid is only dropped for an idle
  // burst, never at acceptance, so words can follow back to back.
  task automatic send_word(input logic [31:0] data, input logic [5:0] count);
    int       gap;
    pdwe_in_t w;
    w.data_word = data;
    w.bit_count = count;
    if (in_idle_en && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    encode_word(w);
  endtask

  // Wait for every owed symbol, then let any trailing resultless words clear.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Timing value with the extremes overweighted; upper bus bits are junk on purpose.
  function automatic logic [31:0] pick_time();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 3))
      0: r[15:0] = 16'h0000;
      1: r[15:0] = 16'hFFFF;
      default: ;
    endcase
    return r;
  endfunction

  // Mostly valid counts, with zero, full width and oversized ones mixed in.
  function automatic logic [5:0] pick_count();
    case ($urandom_range(0, 19))
      0:       return 6'd0;
      1, 2:    return 6'($urandom_range(33, 63));
      3:       return 6'd32;
      4, 5, 6: return 6'($urandom_range(1, 32));
      default: return 6'($urandom_range(1, 12));
    endcase
  endfunction

  // Receiver: random stall bursts, or one long hold-off when a test asks for it.
  initial begin : result_ready_gen
    int n;
    out_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_off_req > 0) begin
        n            = hold_off_req;
        hold_off_req = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end else if (out_idle_en && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 8);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each accepted symbol with the oldest one owed; values are pre-edge.
  always @(posedge clk) begin : symbol_check
    pdwe_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_symbols.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: symbol with none owed: mark=%0d space=%0d stop=%0b last=%0b",
                   $realtime, out_data.mark_time, out_data.space_time,
                   out_data.is_stop, out_data.last_symbol);
      end else begin
        want = pending_symbols.pop_front();
        if (out_data.mark_time !== want.mark_time || out_data.space_time !== want.space_time ||
            out_data.is_stop !== want.is_stop || out_data.last_symbol !== want.last_symbol) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: symbol mismatch: want mark=%0d space=%0d stop=%0b last=%0b, %s",
                     $realtime, want.mark_time, want.space_time, want.is_stop,
                     want.last_symbol,
                     $sformatf("got mark=%0d space=%0d stop=%0b last=%0b",
                               out_data.mark_time, out_data.space_time,
                               out_data.is_stop, out_data.last_symbol));
        end
      end
    end
  end

  // Reset timing: LSB first with stop mark. Cover zero count (stop alone),
  // oversized counts that clamp, and data bits above the count being ignored.
  task automatic test_default_timing();
    send_word(32'h0000_0001, 6'd1);
    send_word(32'hFFFF_FFFF, 6'd32);
    send_word(32'h0000_0000, 6'd32);
    send_word(32'hDEAD_BEEF, 6'd0);
    send_word(32'h8000_0001, 6'd63);
    send_word(32'hA5A5_A5A5, 6'd33);
    send_word(32'hFFFF_FF5A, 6'd8);
    drain_block();
  endtask

  // MSB first, no stop mark: a zero count owes nothing at all. Writes to the
  // spare slots must not disturb the map.
  task automatic test_msb_first_no_stop();
    write_reg(REG_SPARE_6, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_7, 32'hFFFF_FFFF);
    load_timing(32'h0000_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_FFFF,
                32'd1, 32'd0);
    send_word(32'h1234_5678, 6'd0);
    send_word(32'h0000_0001, 6'd1);
    send_word(32'h8000_0000, 6'd32);
    send_word(32'h0001_2345, 6'd17);
    send_word(32'hFFFF_FFFF, 6'd63);
    send_word(32'h0000_0003, 6'd2);
    drain_block();
  endtask

  // Opposite timing extremes, MSB first with stop mark.
  task automatic test_timing_extremes();
    load_timing(32'h0000_0000, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_0000,
                32'd1, 32'd1);
    send_word(32'h5555_5555, 6'd32);
    send_word(32'h0000_0000, 6'd0);
    send_word(32'hFFFF_FFFF, 6'd1);
    send_word(32'h0F0F_0F0F, 6'd31);
    drain_block();
  endtask

  // Several register settings in turn; the first four walk all bit orders and
  // stop options, the first two pin every timing to one extreme.
  task automatic test_random_phases();
    int          p;
    int          k;
    logic [31:0] all_t;
    for (p = 0; p < 6; p++) begin
      in_idle_en  = (p != 2);
      out_idle_en = (p != 3);
      if (p < 2) begin
        all_t = (p == 0) ? 32'h0000_FFFF : 32'h0000_0000;
        load_timing(all_t, all_t, all_t, all_t, 32'(p & 1), 32'((p >> 1) & 1));
      end else if (p < 4) begin
        load_timing(pick_time(), pick_time(), pick_time(), pick_time(),
                    32'(p & 1), 32'((p >> 1) & 1));
      end else begin
        load_timing(pick_time(), pick_time(), pick_time(), pick_time(),
                    $urandom(), $urandom());
      end
      for (k = 0; k < WORDS_PER_PHASE; k++)
        send_word($urandom(), pick_count());
      drain_block();
    end
  endtask

  // Stall the receiver long enough for the queue to fill and in_ready to drop,
  // while the sender keeps offering full-width words.
  task automatic test_output_hold_off();
    int k;
    in_idle_en   = 1'b0;
    out_idle_en  = 1'b1;
    hold_off_req = HOLD_OFF_CYCLES;
    for (k = 0; k < 12; k++)
      send_word($urandom(), 6'd32);
    drain_block();
  endtask

  // Closing stretch with no idling on either side.
  task automatic test_steady_stream();
    int k;
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    load_timing(pick_time(), pick_time(), pick_time(), pick_time(), $urandom(), 32'd1);
    for (k = 0; k < 50; k++)
      send_word($urandom(), pick_count());
    drain_block();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    in_idle_en     = 1'b1;
    out_idle_en    = 1'b1;
    hold_off_req   = 0;
    mismatch_count = 0;
    one_mark_q     = RST_ONE_MARK;
    one_space_q    = RST_ONE_SPACE;
    zero_mark_q    = RST_ZERO_MARK;
    zero_space_q   = RST_ZERO_SPACE;
    msb_first_q    = RST_MSB_FIRST;
    stop_en_q      = RST_SEND_STOP;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_default_timing();
    test_msb_first_no_stop();
    test_timing_extremes();
    test_random_phases();
    test_output_hold_off();
    test_steady_stream();

    if (mismatch_count == 0 && pending_symbols.size() == 0)
      $display("[pulse_distance_width_encoder_unit] OK");
    else
      $display("[pulse_distance_width_encoder_unit] ERROR");
    $finish;
  end

  // Watchdog: a limit several times the slowest legal run.
  initial begin
    #10_000_000;
    $display("[pulse_distance_width_encoder_unit] ERROR");
    $finish;
  end

endmodule
